>>> rtl/sclp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sclp_pkg
// Types, constants and sizes shared by the soft-constraint logistic penalty
// core: channel payloads, row queue entries, divider control, back-end states.
// ----------------------------------------------------------------------------
package sclp_pkg;

   // row queue between front and back
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   // logistic evaluation
   localparam int SAT_ARGUMENT = 16;
   localparam int ZMAG_W       = 56;
   localparam logic [ZMAG_W-1:0] SAT_LIMIT = ZMAG_W'(SAT_ARGUMENT * 65536);
   localparam int TAYLOR_TERMS = 13;
   localparam int KW           = $clog2(TAYLOR_TERMS + 1);
   localparam int SQUARINGS    = 6;
   localparam int SQW          = $clog2(SQUARINGS);

   localparam logic [15:0] SHARP_RESET = 16'd256;

   // shared divider
   localparam int DVD_W       = 64;
   localparam int DVS_W       = 33;
   localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
   localparam int STEPS_FULL  = DVD_W;
   localparam int STEPS_SHORT = DVD_W / 2;

   typedef struct packed {
      logic signed [31:0] coefficient;
      logic signed [31:0] operand_value;
      logic signed [31:0] row_bound;
      logic               last_term;
   } req_payload_type;

   typedef struct packed {
      logic [16:0] smooth_step;
      logic [14:0] step_slope;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] row_sum;
      logic [31:0] bound;
   } q_entry_type;

   typedef struct packed {
      logic        push;
      q_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic           empty;
      logic [QCW-1:0] count;
   } q_stat_type;

   typedef struct packed {
      logic             start;
      logic             short_mode;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [4:0] {
      BK_IDLE,
      BK_DIFF,
      BK_MAG,
      BK_ZHI,
      BK_ZLO,
      BK_ZSUM,
      BK_ZCHK,
      BK_TMUL,
      BK_TDIV,
      BK_TWAIT,
      BK_CLAMP,
      BK_SQMUL,
      BK_SQRND,
      BK_SDIV,
      BK_SWAIT,
      BK_QDIV,
      BK_QWAIT,
      BK_SMUL,
      BK_SRND,
      BK_DONE
   } back_state_type;

endpackage
`default_nettype wire

>>> rtl/sclp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sclp_front
// Term intake: registered signed product, row accumulation, and hand-off of
// each finished row sum with its bound to the row queue.
// ----------------------------------------------------------------------------
module sclp_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire sclp_pkg::req_payload_type req_data,
   input  wire sclp_pkg::q_stat_type     q_stat,
   output sclp_pkg::q_push_type          q_push
);

   logic               accept;
   logic signed [63:0] prod_in;
   logic signed [63:0] prod_ff;
   logic               vld_ff;
   logic               last_ff;
   logic [31:0]        bound_ff;
   logic [63:0]        acc_ff;
   logic [63:0]        acc_in;
   logic [63:0]        row_sum;
   logic [sclp_pkg::QCW:0] committed;

   // reserve a queue slot for a row end still in the product stage
   assign committed = {1'b0, q_stat.count} + (sclp_pkg::QCW + 1)'(vld_ff & last_ff);
   assign req_stall = committed >= (sclp_pkg::QCW + 1)'(sclp_pkg::QDEPTH);
   assign accept    = req_valid & ~req_stall;

   assign prod_in = req_data.coefficient * req_data.operand_value;
   assign row_sum = acc_ff + prod_ff;

   always_comb begin
      acc_in             = acc_ff;
      q_push.push        = 1'b0;
      q_push.entry.row_sum = row_sum;
      q_push.entry.bound = bound_ff;
      if (vld_ff) begin
         if (last_ff) begin
            q_push.push = 1'b1;
            acc_in      = '0;
         end else begin
            acc_in = row_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         vld_ff <= accept;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff  <= prod_in;
         last_ff  <= req_data.last_term;
         bound_ff <= req_data.row_bound;
      end
   end

endmodule
`default_nettype wire

>>> rtl/sclp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sclp_queue
// Short register queue of finished row sums between the term intake and the
// logistic back end.
// ----------------------------------------------------------------------------
module sclp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sclp_pkg::q_push_type q_push,
   input  wire logic                 q_pop,
   output sclp_pkg::q_entry_type     q_head,
   output sclp_pkg::q_stat_type      q_stat
);

   sclp_pkg::q_entry_type entries_ff [sclp_pkg::QDEPTH];
   logic [sclp_pkg::QAW-1:0] wr_ptr_ff;
   logic [sclp_pkg::QAW-1:0] rd_ptr_ff;
   logic [sclp_pkg::QCW-1:0] count_ff;
   logic [sclp_pkg::QCW-1:0] count_in;

   assign q_head       = entries_ff[rd_ptr_ff];
   assign q_stat.count = count_ff;
   assign q_stat.empty = count_ff == '0;

   always_comb begin
      count_in = count_ff;
      case ({q_push.push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         entries_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule
`default_nettype wire

>>> rtl/sclp_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sclp_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle. Short mode
// runs half the steps on a dividend whose low half is zero.
// ----------------------------------------------------------------------------
module sclp_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sclp_pkg::div_req_type div_req,
   output logic                       div_busy,
   output logic [sclp_pkg::DVD_W-1:0] div_quot
);

   logic                           busy_ff;
   logic [sclp_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [sclp_pkg::DVS_W-1:0]     rem_ff;
   logic [sclp_pkg::DVD_W-1:0]     qd_ff;
   logic [sclp_pkg::DVS_W-1:0]     dvs_ff;
   logic [sclp_pkg::DVS_W:0]       shifted;
   logic [sclp_pkg::DVS_W+1:0]     trial;
   logic                           fits;

   assign shifted  = {rem_ff, qd_ff[sclp_pkg::DVD_W-1]};
   assign trial    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fits     = ~trial[sclp_pkg::DVS_W+1];
   assign div_busy = busy_ff;
   assign div_quot = qd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (div_req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= div_req.short_mode ? sclp_pkg::DIV_CNT_W'(sclp_pkg::STEPS_SHORT)
                                       : sclp_pkg::DIV_CNT_W'(sclp_pkg::STEPS_FULL);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == sclp_pkg::DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         qd_ff  <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits suffice
         rem_ff <= fits ? trial[sclp_pkg::DVS_W-1:0] : shifted[sclp_pkg::DVS_W-1:0];
         qd_ff  <= {qd_ff[sclp_pkg::DVD_W-2:0], fits};
      end
   end

endmodule
`default_nettype wire

>>> rtl/sclp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sclp_back
// Logistic back end: bound difference, sharpness scaling, saturation check,
// exp(-|z|) by Taylor series and repeated squaring, logistic value and slope,
// with a shared multiplier, a shared divider and an output register.
// ----------------------------------------------------------------------------
module sclp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           sharpness,
   input  wire sclp_pkg::q_stat_type  q_stat,
   input  wire sclp_pkg::q_entry_type q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sclp_pkg::rsp_payload_type  rsp_data
);

   sclp_pkg::back_state_type state_ff, state_in;

   logic [63:0]                 acc_ff, acc_in;
   logic [31:0]                 bnd_ff, bnd_in;
   logic [63:0]                 d_ff, d_in;
   logic                        neg_ff, neg_in;
   logic [63:0]                 mag_ff, mag_in;
   logic [47:0]                 phi_ff, phi_in;
   logic [sclp_pkg::ZMAG_W-1:0] zmag_ff, zmag_in;
   logic [31:0]                 w_ff, w_in;
   logic [32:0]                 term_ff, term_in;
   logic signed [36:0]          sum_ff, sum_in;
   logic [sclp_pkg::KW-1:0]     k_ff, k_in;
   logic [31:0]                 e_ff, e_in;
   logic [sclp_pkg::SQW-1:0]    sq_ff, sq_in;
   logic [16:0]                 smooth_ff, smooth_in;
   logic [31:0]                 q_ff, q_in;
   logic [14:0]                 slope_ff, slope_in;
   logic [65:0]                 mul_ff;
   logic [32:0]                 mul_a, mul_b;
   logic                        rsp_vld_ff, rsp_vld_in;
   sclp_pkg::rsp_payload_type   rsp_data_ff, rsp_data_in;

   sclp_pkg::div_req_type       div_req;
   logic                        div_busy;
   logic [sclp_pkg::DVD_W-1:0]  div_quot;

   logic                        sat_hit;
   logic                        out_free;
   logic [32:0]                 den;
   logic [31:0]                 den_half;
   logic [65:0]                 rnd_sq;
   logic [65:0]                 rnd_slope;
   logic [32:0]                 tq;

   sclp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_busy (div_busy),
      .div_quot (div_quot)
   );

   assign sat_hit   = zmag_ff >= sclp_pkg::SAT_LIMIT;
   assign out_free  = ~rsp_vld_ff | ~rsp_stall;
   assign den       = {1'b1, e_ff};
   assign den_half  = {1'b1, e_ff[31:1]};
   assign rnd_sq    = mul_ff + 66'h8000_0000;
   assign rnd_slope = mul_ff + 66'h8000_0000_0000;
   assign tq        = div_quot[32:0];
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sclp_pkg::BK_IDLE:  if (!q_stat.empty) state_in = sclp_pkg::BK_DIFF;
         sclp_pkg::BK_DIFF:  state_in = sclp_pkg::BK_MAG;
         sclp_pkg::BK_MAG:   state_in = sclp_pkg::BK_ZHI;
         sclp_pkg::BK_ZHI:   state_in = sclp_pkg::BK_ZLO;
         sclp_pkg::BK_ZLO:   state_in = sclp_pkg::BK_ZSUM;
         sclp_pkg::BK_ZSUM:  state_in = sclp_pkg::BK_ZCHK;
         sclp_pkg::BK_ZCHK:  state_in = sat_hit ? sclp_pkg::BK_DONE : sclp_pkg::BK_TMUL;
         sclp_pkg::BK_TMUL:  state_in = sclp_pkg::BK_TDIV;
         sclp_pkg::BK_TDIV:  state_in = sclp_pkg::BK_TWAIT;
         sclp_pkg::BK_TWAIT: begin
            if (!div_busy) begin
               state_in = (k_ff == sclp_pkg::KW'(sclp_pkg::TAYLOR_TERMS))
                          ? sclp_pkg::BK_CLAMP : sclp_pkg::BK_TMUL;
            end
         end
         sclp_pkg::BK_CLAMP: state_in = sclp_pkg::BK_SQMUL;
         sclp_pkg::BK_SQMUL: state_in = sclp_pkg::BK_SQRND;
         sclp_pkg::BK_SQRND: begin
            state_in = (sq_ff == sclp_pkg::SQW'(sclp_pkg::SQUARINGS - 1))
                       ? sclp_pkg::BK_SDIV : sclp_pkg::BK_SQMUL;
         end
         sclp_pkg::BK_SDIV:  state_in = sclp_pkg::BK_SWAIT;
         sclp_pkg::BK_SWAIT: if (!div_busy) state_in = sclp_pkg::BK_QDIV;
         sclp_pkg::BK_QDIV:  state_in = sclp_pkg::BK_QWAIT;
         sclp_pkg::BK_QWAIT: if (!div_busy) state_in = sclp_pkg::BK_SMUL;
         sclp_pkg::BK_SMUL:  state_in = sclp_pkg::BK_SRND;
         sclp_pkg::BK_SRND:  state_in = sclp_pkg::BK_DONE;
         sclp_pkg::BK_DONE:  if (out_free) state_in = sclp_pkg::BK_IDLE;
         default:            state_in = sclp_pkg::BK_IDLE;
      endcase
   end

   // datapath controls and register updates
   always_comb begin
      acc_in      = acc_ff;
      bnd_in      = bnd_ff;
      d_in        = d_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      phi_in      = phi_ff;
      zmag_in     = zmag_ff;
      w_in        = w_ff;
      term_in     = term_ff;
      sum_in      = sum_ff;
      k_in        = k_ff;
      e_in        = e_ff;
      sq_in       = sq_ff;
      smooth_in   = smooth_ff;
      q_in        = q_ff;
      slope_in    = slope_ff;
      mul_a       = '0;
      mul_b       = '0;
      div_req     = '0;
      q_pop       = 1'b0;
      rsp_data_in = rsp_data_ff;
      rsp_vld_in  = rsp_vld_ff & rsp_stall;
      unique case (state_ff)
         sclp_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop  = 1'b1;
               acc_in = q_head.row_sum;
               bnd_in = q_head.bound;
            end
         end
         sclp_pkg::BK_DIFF: begin
            d_in = acc_ff - {{16{bnd_ff[31]}}, bnd_ff, 16'h0000};
         end
         sclp_pkg::BK_MAG: begin
            neg_in = d_ff[63];
            mag_in = d_ff[63] ? (64'd0 - d_ff) : d_ff;
         end
         sclp_pkg::BK_ZHI: begin
            mul_a = {1'b0, mag_ff[63:32]};
            mul_b = {17'd0, sharpness};
         end
         sclp_pkg::BK_ZLO: begin
            mul_a  = {1'b0, mag_ff[31:0]};
            mul_b  = {17'd0, sharpness};
            phi_in = mul_ff[47:0];
         end
         sclp_pkg::BK_ZSUM: begin
            zmag_in = {phi_ff, 8'h00} + sclp_pkg::ZMAG_W'(mul_ff[47:24]);
         end
         sclp_pkg::BK_ZCHK: begin
            if (sat_hit) begin
               smooth_in = neg_ff ? 17'd0 : 17'd65536;
               slope_in  = '0;
            end else begin
               // below the limit |z| has at most 20 bits, so w is exact
               w_in    = {zmag_ff[21:0], 10'd0};
               term_in = 33'h1_0000_0000;
               sum_in  = 37'sh1_0000_0000;
               k_in    = sclp_pkg::KW'(1);
            end
         end
         sclp_pkg::BK_TMUL: begin
            mul_a = term_ff;
            mul_b = {1'b0, w_ff};
         end
         sclp_pkg::BK_TDIV: begin
            div_req.start      = 1'b1;
            div_req.short_mode = 1'b1;
            div_req.dividend   = {mul_ff[63:32], 32'd0};
            div_req.divisor    = sclp_pkg::DVS_W'(k_ff);
         end
         sclp_pkg::BK_TWAIT: begin
            if (!div_busy) begin
               term_in = tq;
               sum_in  = k_ff[0] ? (sum_ff - $signed({4'd0, tq}))
                                 : (sum_ff + $signed({4'd0, tq}));
               k_in    = k_ff + 1'b1;
            end
         end
         sclp_pkg::BK_CLAMP: begin
            if (sum_ff[36]) begin
               e_in = '0;
            end else if (|sum_ff[35:32]) begin
               e_in = 32'hFFFF_FFFF;
            end else begin
               e_in = sum_ff[31:0];
            end
            sq_in = '0;
         end
         sclp_pkg::BK_SQMUL: begin
            mul_a = {1'b0, e_ff};
            mul_b = {1'b0, e_ff};
         end
         sclp_pkg::BK_SQRND: begin
            e_in  = rnd_sq[63:32];
            sq_in = sq_ff + 1'b1;
         end
         sclp_pkg::BK_SDIV: begin
            div_req.start      = 1'b1;
            div_req.short_mode = 1'b0;
            div_req.dividend   = neg_ff ? ({16'd0, e_ff, 16'd0} + {32'd0, den_half})
                                        : (64'h1_0000_0000_0000 + {32'd0, den_half});
            div_req.divisor    = den;
         end
         sclp_pkg::BK_SWAIT: begin
            if (!div_busy) smooth_in = div_quot[16:0];
         end
         sclp_pkg::BK_QDIV: begin
            div_req.start      = 1'b1;
            div_req.short_mode = 1'b0;
            div_req.dividend   = {e_ff, 32'd0};
            div_req.divisor    = den;
         end
         sclp_pkg::BK_QWAIT: begin
            if (!div_busy) q_in = div_quot[31:0];
         end
         sclp_pkg::BK_SMUL: begin
            mul_a = {1'b0, q_ff};
            mul_b = 33'h1_0000_0000 - {1'b0, q_ff};
         end
         sclp_pkg::BK_SRND: begin
            slope_in = rnd_slope[62:48];
         end
         sclp_pkg::BK_DONE: begin
            if (out_free) begin
               rsp_vld_in              = 1'b1;
               rsp_data_in.smooth_step = smooth_ff;
               rsp_data_in.step_slope  = slope_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sclp_pkg::BK_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      bnd_ff      <= bnd_in;
      d_ff        <= d_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      phi_ff      <= phi_in;
      zmag_ff     <= zmag_in;
      w_ff        <= w_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      k_ff        <= k_in;
      e_ff        <= e_in;
      sq_ff       <= sq_in;
      smooth_ff   <= smooth_in;
      q_ff        <= q_in;
      slope_ff    <= slope_in;
      mul_ff      <= mul_a * mul_b;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

>>> rtl/soft_constraint_logistic_penalty_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soft_constraint_logistic_penalty_core
// Multiply-accumulates constraint row terms and returns the logistic penalty
// value and slope of each finished row.
// ----------------------------------------------------------------------------
// Terms are taken one per cycle while the four-entry row queue has room; a
// term passes through the product and accumulate stages. Each row end is
// then evaluated by a back end built around one 33x33 multiplier and one
// radix-2 divider: an unsaturated row runs 13 Taylor divisions in short mode
// and two full divisions, while a saturated row skips them. A finished result
// sits in the output register until taken, while the intake keeps filling the
// queue. The sharpness register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module soft_constraint_logistic_penalty_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire sclp_pkg::req_payload_type req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output sclp_pkg::rsp_payload_type      rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [15:0]               csr_wr_data
);

   logic [15:0]           sharpness_ff;
   sclp_pkg::q_push_type  q_push;
   sclp_pkg::q_stat_type  q_stat;
   sclp_pkg::q_entry_type q_head;
   logic                  q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         sharpness_ff <= sclp_pkg::SHARP_RESET;
      end else if (csr_wr_en) begin
         sharpness_ff <= csr_wr_data;
      end
   end

   sclp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_push    (q_push)
   );

   sclp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_head (q_head),
      .q_stat (q_stat)
   );

   sclp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .sharpness (sharpness_ff),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= sclp_pkg::QCW'(sclp_pkg::QDEPTH))
      else $error("row queue count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> (q_stat.count != sclp_pkg::QCW'(sclp_pkg::QDEPTH)))
      else $error("row pushed into a full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("row popped from an empty queue");

   a_slope_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.step_slope <= 15'd16384))
      else $error("logistic slope above one quarter");

endmodule
`default_nettype wire

>>> bench/tb_soft_constraint_logistic_penalty_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_soft_constraint_logistic_penalty_core
// Streams constraint row terms into the penalty core and checks every
// logistic value and slope against a bit-exact fixed-point predictor. Covers
// threshold and saturation corners, accumulator wrap, sharpness extremes,
// long output back-pressure and random rows with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_soft_constraint_logistic_penalty_core;

   localparam int SETTLE_CYCLES = 700;
   localparam int LONG_HOLD     = 4000;
   localparam int CYCLE_LIMIT   = 4_000_000;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   sclp_pkg::req_payload_type req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   sclp_pkg::rsp_payload_type rsp_data;
   logic                      csr_wr_en   = 1'b0;
   logic [15:0]               csr_wr_data = '0;

   // predictor state
   bit [63:0]                 row_sum_model;
   bit [15:0]                 sharpness_model;
   sclp_pkg::rsp_payload_type pending_penalties[$];

   int fail_count  = 0;
   int cycle_count = 0;

   // sender side gaps (initial block only); sink side controls (by nonblocking)
   bit gaps_on         = 1'b0;
   bit sink_bursts_on  = 1'b0;
   bit hold_request    = 1'b0;
   bit hold_served     = 1'b0;
   int hold_left       = 0;
   int burst_left      = 0;

   soft_constraint_logistic_penalty_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL soft_constraint_logistic_penalty_core");
         $finish;
      end
   end

   // exp(-|z|) in Q0.32: Taylor series at |z|/64, then squared back up
   function automatic bit [63:0] exp_neg_q32(input bit [63:0] zmag);
      bit [63:0]      w;
      bit [63:0]      term;
      bit [63:0]      e;
      longint signed  total;
      int             k;
      w     = (zmag << 10) & 64'hFFFF_FFFF;
      term  = 64'd1 << 32;
      total = longint'(term);
      for (k = 1; k <= sclp_pkg::TAYLOR_TERMS; k++) begin
         term = ((term * w) >> 32) / 64'(k);
         if (k % 2 == 1) total -= longint'(term);
         else total += longint'(term);
      end
      if (total < 0) total = 0;
      if (total > longint'(64'hFFFF_FFFF)) total = longint'(64'hFFFF_FFFF);
      e = 64'(total);
      for (k = 0; k < sclp_pkg::SQUARINGS; k++)
         e = (e * e + (64'd1 << 31)) >> 32;
      return e;
   endfunction

   // absorb one accepted term; on a row end, queue the expected penalty
   function automatic void predict_penalty(input sclp_pkg::req_payload_type t);
      bit [63:0]                 diff;
      bit [63:0]                 mag;
      bit [63:0]                 zmag;
      bit [63:0]                 sharp;
      bit [63:0]                 e;
      bit [63:0]                 den;
      bit [63:0]                 q;
      bit [63:0]                 smooth;
      bit [63:0]                 slope;
      bit                        neg;
      sclp_pkg::rsp_payload_type r;
      row_sum_model += 64'(longint'(t.coefficient) * longint'(t.operand_value));
      if (!t.last_term) return;
      diff          = row_sum_model - (64'(longint'(t.row_bound)) << 16);
      row_sum_model = '0;
      neg   = diff[63];
      mag   = neg ? (64'd0 - diff) : diff;
      sharp = 64'(sharpness_model);
      zmag  = (((mag >> 32) * sharp) << 8) + (((mag & 64'hFFFF_FFFF) * sharp) >> 24);
      if (zmag >= (64'(sclp_pkg::SAT_ARGUMENT) << 16)) begin
         r.smooth_step = neg ? 17'd0 : 17'd65536;
         r.step_slope  = '0;
      end else begin
         e   = exp_neg_q32(zmag);
         den = (64'd1 << 32) + e;
         if (neg) smooth = ((e << 16) + den / 2) / den;
         else smooth = ((64'd1 << 48) + den / 2) / den;
         q     = (e << 32) / den;
         slope = (q * ((64'd1 << 32) - q) + (64'd1 << 47)) >> 48;
         r.smooth_step = smooth[16:0];
         r.step_slope  = slope[14:0];
      end
      pending_penalties.push_back(r);
   endfunction

   // receiver pacing: one long hold on request, else random stall bursts when enabled
   always @(posedge clock) begin
      if (hold_request && !hold_served) begin
         hold_served <= 1'b1;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left != 1);
      end else begin
         if (!hold_request) hold_served <= 1'b0;
         if (!sink_bursts_on) begin
            rsp_stall <= 1'b0;
         end else if (burst_left != 0) begin
            burst_left <= burst_left - 1;
            rsp_stall  <= (burst_left != 1);
         end else if ($urandom_range(0, 7) == 0) begin
            burst_left <= $urandom_range(1, 15);
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      sclp_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_penalties.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual smooth_step %0d step_slope %0d",
                     $time, rsp_data.smooth_step, rsp_data.step_slope);
            fail_count++;
         end else begin
            want = pending_penalties.pop_front();
            if (rsp_data.smooth_step !== want.smooth_step) begin
               $display("%0t: smooth_step mismatch: expected %0d, actual %0d",
                        $time, want.smooth_step, rsp_data.smooth_step);
               fail_count++;
            end
            if (rsp_data.step_slope !== want.step_slope) begin
               $display("%0t: step_slope mismatch: expected %0d, actual %0d",
                        $time, want.step_slope, rsp_data.step_slope);
               fail_count++;
            end
         end
      end
   end

   // offer one item and hold it until taken; valid stays high for the next
   task automatic send_term(input sclp_pkg::req_payload_type t);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_penalty(t);
   endtask

   task automatic send_fields(input logic signed [31:0] c, input logic signed [31:0] x,
                              input logic signed [31:0] b, input bit last);
      sclp_pkg::req_payload_type t;
      t.coefficient   = c;
      t.operand_value = x;
      t.row_bound     = b;
      t.last_term     = last;
      send_term(t);
   endtask

   // drop valid and wait until every expected item is back, then let it settle
   task automatic settle_results;
      req_valid <= 1'b0;
      while (pending_penalties.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sharpness(input bit [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      sharpness_model  = v;
   endtask

   function automatic logic [31:0] spread(input int unsigned half);
      return 32'($urandom_range(0, 2 * half)) - 32'(half);
   endfunction

   task automatic test_reset_sharpness_corners;
      // zero row gives one half
      send_fields(32'sd0, 32'sd0, 32'sd0, 1'b1);
      // far beyond either side
      send_fields(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
      send_fields(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
      // right on the saturation threshold and one LSB inside it
      send_fields(32'sd16 <<< 16, 32'sd1 <<< 16, 32'sd0, 1'b1);
      send_fields(32'sd16 <<< 16, 32'sd1 <<< 16, 32'sd1, 1'b1);
      send_fields(-(32'sd16 <<< 16), 32'sd1 <<< 16, 32'sd0, 1'b1);
      send_fields(-(32'sd16 <<< 16), 32'sd1 <<< 16, -32'sd1, 1'b1);
      // four maximal products wrap the sum to zero; bounds on inner terms are ignored
      repeat (4) send_fields(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      send_fields(32'sd0, 32'sd0, 32'sd0, 1'b1);
      // row sum wraps past the sign bit
      repeat (2) send_fields(32'sh8000_0000, 32'sh8000_0000, 32'sd0, 1'b0);
      send_fields(32'sd0, 32'sd0, 32'sh8000_0000, 1'b1);
      settle_results();
   endtask

   task automatic test_sharpness_extremes;
      write_sharpness(16'd0);
      send_fields(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
      settle_results();
      write_sharpness(16'hFFFF);
      send_fields(32'sd1, 32'sd1, 32'sd0, 1'b1);
      send_fields(32'sd1 <<< 16, 32'sd1 <<< 8, -32'sd3, 1'b1);
      settle_results();
      write_sharpness(16'd1);
      send_fields(32'sd16 <<< 16, 32'sd1 <<< 16, 32'sd0, 1'b1);
      send_fields(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd5, 1'b1);
      settle_results();
   endtask

   // hold the output long enough for the queue to fill and stall the intake
   task automatic test_output_backpressure;
      int k;
      gaps_on = 1'b0;
      write_sharpness(sclp_pkg::SHARP_RESET);
      hold_request <= 1'b1;
      for (k = 0; k < 12; k++) begin
         if (k % 2 == 0) send_fields(spread(1 << 16), spread(1 << 18), spread(1 << 18), 1'b1);
         else send_fields($urandom, $urandom, $urandom, 1'b1);
      end
      hold_request <= 1'b0;
      settle_results();
   endtask

   task automatic send_random_row(output int sent);
      int                        len;
      int                        style;
      int                        k;
      sclp_pkg::req_payload_type t;
      style = $urandom_range(0, 19);
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      for (k = 0; k < len; k++) begin
         t.last_term = (k == len - 1);
         t.row_bound = $urandom;
         if (style < 15 && $urandom_range(0, 29) != 0) begin
            t.coefficient   = spread(1 << 16);
            t.operand_value = spread(1 << 18);
            if (t.last_term) t.row_bound = spread(1 << 18);
         end else if (style < 17) begin
            t.coefficient   = spread(1 << 24);
            t.operand_value = spread(1 << 24);
            if (t.last_term) t.row_bound = spread(1 << 26);
         end else begin
            t.coefficient   = $urandom;
            t.operand_value = $urandom;
         end
         send_term(t);
      end
      sent = len;
   endtask

   task automatic test_random_rows(input int item_budget, input bit [15:0] sharp,
                                   input bit with_idling);
      int done;
      int sent;
      gaps_on         = with_idling;
      sink_bursts_on <= with_idling;
      write_sharpness(sharp);
      done = 0;
      while (done < item_budget) begin
         send_random_row(sent);
         done += sent;
      end
      settle_results();
   endtask

   initial begin
      row_sum_model   = '0;
      sharpness_model = sclp_pkg::SHARP_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_sharpness_corners();
      test_sharpness_extremes();
      test_output_backpressure();
      test_random_rows(224, sclp_pkg::SHARP_RESET, 1'b1);
      test_random_rows(224, 16'($urandom_range(1, 65535)), 1'b1);
      test_random_rows(224, 16'($urandom_range(16, 1024)), 1'b1);
      test_random_rows(224, 16'($urandom_range(1, 64)), 1'b1);
      // final stretch runs with no idling on either side
      test_random_rows(224, sclp_pkg::SHARP_RESET, 1'b0);

      if (fail_count == 0) begin
         $display("PASS soft_constraint_logistic_penalty_core");
      end else begin
         $display("FAIL soft_constraint_logistic_penalty_core");
      end
      $finish;
   end

endmodule

>>> soft_constraint_logistic_penalty_core.f
rtl/sclp_pkg.sv
rtl/sclp_front.sv
rtl/sclp_queue.sv
rtl/sclp_divider.sv
rtl/sclp_back.sv
rtl/soft_constraint_logistic_penalty_core.sv
bench/tb_soft_constraint_logistic_penalty_core.sv
